// ===== design/ckre_pkg.sv =====
// Shared types, constants and helpers for the color key run extractor.
package ckre_pkg;

  localparam int unsigned MaxDim = 4096;
  localparam int unsigned ColW   = 12;   // column / row counter width
  localparam int unsigned DimW   = 13;   // dimension width, holds MaxDim
  localparam int unsigned PixW   = 24;

  localparam logic [PixW-1:0] KeyColorRst    = 24'hFCBC14;  // RGB(20,188,252)
  localparam logic [DimW-1:0] FrameWidthRst  = 13'd640;
  localparam logic [DimW-1:0] FrameHeightRst = 13'd480;

  typedef enum logic [1:0] {
    CFG_KEY_COLOR    = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  // Settings as the scan logic uses them: dimensions already clamped.
  typedef struct packed {
    logic [PixW-1:0] key_color;
    logic [DimW-1:0] eff_w;
    logic [ColW-1:0] last_col;
    logic [ColW-1:0] last_row;
  } cfg_t;

  typedef struct packed {
    logic [ColW-1:0] run_start;
    logic [DimW-1:0] run_end;
    logic [ColW-1:0] run_row;
  } run_t;

  typedef struct packed {
    logic main_vld;
    logic skid_vld;
  } buf_stat_t;

  // Zero counts as one, anything above the maximum as the maximum.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/ckre_scan.sv =====
// Pixel input register, column/row counters and run open/close detection.
module ckre_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [23:0]           pixel_color_i,
  input  ckre_pkg::cfg_t        cfg_i,
  input  ckre_pkg::buf_stat_t   stat_i,
  output logic                  res_vld_o,
  output ckre_pkg::run_t        res_o
);
  import ckre_pkg::*;

  logic [PixW-1:0] pix_q;
  logic            pix_vld_q, pix_vld_d;
  logic [ColW-1:0] col_q, col_d;
  logic [ColW-1:0] row_q, row_d;
  logic            open_q, open_d;
  logic [ColW-1:0] start_q, start_d;

  logic advance, in_acc, is_key, col_end, close_key;

  // The pixel is worked on when the output side has a free slot.
  assign advance    = pix_vld_q && !stat_i.skid_vld;
  assign in_stall_o = pix_vld_q && stat_i.skid_vld;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_key    = (pix_q == cfg_i.key_color);
  assign col_end   = (col_q >= cfg_i.last_col);
  assign close_key = open_q && is_key;

  always_comb begin
    pix_vld_d = in_acc ? 1'b1 : (advance ? 1'b0 : pix_vld_q);
    col_d     = col_q;
    row_d     = row_q;
    open_d    = open_q;
    start_d   = start_q;
    if (advance) begin
      if (!open_q && !is_key) begin
        start_d = col_q;
      end
      if (col_end) begin
        open_d = 1'b0;
        col_d  = '0;
        row_d  = (row_q >= cfg_i.last_row) ? '0 : row_q + ColW'(1);
      end else begin
        open_d = !is_key;
        col_d  = col_q + ColW'(1);
      end
    end
  end

  // A key pixel closes an open run; otherwise a solid pixel at row end does.
  assign res_vld_o         = advance && (close_key || (col_end && !is_key));
  assign res_o.run_start   = start_d;
  assign res_o.run_end     = close_key ? {1'b0, col_q} : cfg_i.eff_w;
  assign res_o.run_row     = (row_q <= cfg_i.last_row) ? (cfg_i.last_row - row_q) : '0;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q <= pixel_color_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      open_q    <= 1'b0;
      start_q   <= '0;
    end else begin
      pix_vld_q <= pix_vld_d;
      col_q     <= col_d;
      row_q     <= row_d;
      open_q    <= open_d;
      start_q   <= start_d;
    end
  end

endmodule

// ===== design/ckre_outbuf.sv =====
// Two-entry result buffer: output register plus skid entry.
module ckre_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ckre_pkg::run_t       push_data_i,
  output ckre_pkg::buf_stat_t  stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ckre_pkg::run_t       out_data_o
);
  import ckre_pkg::*;

  run_t main_q, main_d, skid_q, skid_d;
  logic main_vld_q, main_vld_d, skid_vld_q, skid_vld_d;
  logic pop;

  assign pop = main_vld_q && !out_stall_i;

  // push is only raised while the skid entry is empty
  always_comb begin
    main_d     = main_q;
    skid_d     = skid_q;
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (pop) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (!main_vld_q || pop) begin
      main_d     = push_data_i;
      main_vld_d = push_i;
    end else if (push_i) begin
      skid_d     = push_data_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  assign stat_o.main_vld = main_vld_q;
  assign stat_o.skid_vld = skid_vld_q;
  assign out_valid_o     = main_vld_q;
  assign out_data_o      = main_q;

endmodule

// ===== design/color_key_run_extractor.sv =====
// Top level: color key run extractor with config registers and assertions.
//
// Usage:
//   Pixels enter on the in channel (in_valid_i / in_stall_o, pixel_color_i),
//   one frame in raster order, bottom image row first. Each pixel that does
//   not match key_color is solid; each maximal horizontal stretch of solid
//   pixels in a row leaves on the out channel as one item (run_start_o,
//   exclusive run_end_o, run_row_o with the top row as zero).
//   Registers are written on the cfg channel (index 0 key color, 1 frame
//   width, 2 frame height); cfg_ready_o is always high, other indexes are
//   ignored. Width/height come from the low 13 data bits; of those, zero
//   acts as 1 and above 4096 as 4096. Throughput: one pixel per clock
//   while in_stall_o is low. A run item passes the input register and then
//   the result register (or the skid entry) before it leaves on out.
//   Reset clears the counters, the open run and both buffer entries and
//   loads the register defaults (key RGB(20,188,252), 640 x 480).
//   When the receiver stalls, the output item holds and one more item is
//   parked in a skid entry; only once that entry fills does in_stall_o rise.
module color_key_run_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] pixel_color_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] run_start_o,
  output logic [12:0] run_end_o,
  output logic [11:0] run_row_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import ckre_pkg::*;

  cfg_t      cfg_q;
  buf_stat_t stat;
  run_t      res, out_data;
  logic      res_vld;
  logic      cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Dimensions are clamped at write time; last column/row kept alongside.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_color <= KeyColorRst;
      cfg_q.eff_w     <= FrameWidthRst;
      cfg_q.last_col  <= ColW'(FrameWidthRst - DimW'(1));
      cfg_q.last_row  <= ColW'(FrameHeightRst - DimW'(1));
    end else if (cfg_wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_COLOR: begin
          cfg_q.key_color <= cfg_data_i;
        end
        CFG_FRAME_WIDTH: begin
          cfg_q.eff_w    <= clamp_dim(cfg_data_i[DimW-1:0]);
          cfg_q.last_col <= ColW'(clamp_dim(cfg_data_i[DimW-1:0]) - DimW'(1));
        end
        CFG_FRAME_HEIGHT: begin
          cfg_q.last_row <= ColW'(clamp_dim(cfg_data_i[DimW-1:0]) - DimW'(1));
        end
        default: begin
        end
      endcase
    end
  end

  ckre_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_color_i (pixel_color_i),
    .cfg_i         (cfg_q),
    .stat_i        (stat),
    .res_vld_o     (res_vld),
    .res_o         (res)
  );

  ckre_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign run_start_o = out_data.run_start;
  assign run_end_o   = out_data.run_end;
  assign run_row_o   = out_data.run_row;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // The skid entry is only ever filled behind a held output item.
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.skid_vld |-> stat.main_vld)
    else $error("skid entry valid with empty output register");

  // A result is never produced while the buffer has no room for it.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> !stat.skid_vld)
    else $error("run produced with full result buffer");

  // Output taken, nothing parked and nothing new: output goes empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !stat.skid_vld && !res_vld) |=> !out_valid_o)
    else $error("output item repeated after it was taken");

  // A width write of zero acts as a one-pixel row.
  a_width_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_index_i == CFG_FRAME_WIDTH && cfg_data_i[DimW-1:0] == '0)
      |=> (cfg_q.eff_w == DimW'(1) && cfg_q.last_col == '0))
    else $error("zero frame width not clamped to one");

endmodule
